[rtl/rsrr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsrr_pkg: shared types and constants of the raster shear/roll remapper
// Holds the register map, the command record that travels from the front
// end to the back end, the divider handshake records and the FSM states.
// ----------------------------------------------------------------------------
package rsrr_pkg;

   // Request payload layout: col, row, red, green, blue, alpha from bit 0 up.
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 32;
   localparam int CSR_DATA_BITS = 15;
   localparam int CSR_INDEX_BITS = 3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_SHEAR_Q8     = 3'd2,
      REG_FLAG_AMP_Q8  = 3'd3,
      REG_FLAG_HEIGHT  = 3'd4,
      REG_ROLL_OFFSET  = 3'd5
   } csr_index_type;

   localparam logic [9:0]  RST_FRAME_WIDTH  = 10'd512;
   localparam logic [9:0]  RST_FRAME_HEIGHT = 10'd512;
   localparam logic [10:0] RST_SHEAR_Q8     = 11'd38;
   localparam logic [14:0] RST_FLAG_AMP_Q8  = 15'd3072;
   localparam logic [8:0]  RST_FLAG_HEIGHT  = 9'd48;
   localparam logic [9:0]  RST_ROLL_OFFSET  = 10'd0;

   typedef struct packed {
      logic [9:0]         frame_width;
      logic [9:0]         frame_height;
      logic signed [10:0] shear_q8;
      logic [14:0]        flag_amplitude_q8;
      logic [8:0]         flag_height;
      logic [9:0]         roll_offset;
   } cfg_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // One queued command. Writes carry the pixel, reads carry the bar flag.
   typedef struct packed {
      logic      is_read;
      logic      in_blank;
      pixel_type pix;
   } cmd_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // Shared restoring divider. The quotient never exceeds 12 bits here.
   localparam int DIV_NUM_BITS = 38;
   localparam int DIV_DEN_BITS = 26;
   localparam int DIV_QUO_BITS = 12;
   localparam int DIV_CNT_BITS = 4;
   localparam int DIV_SHIFT_BITS = DIV_DEN_BITS + DIV_QUO_BITS - 1;

   typedef struct packed {
      logic                    start;
      logic [DIV_NUM_BITS-1:0] dividend;
      logic [DIV_DEN_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                    busy;
      logic [DIV_QUO_BITS-1:0] quo;
      logic [DIV_NUM_BITS-1:0] rem;
   } div_status_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_MUL1,
      FS_MUL2,
      FS_SUM,
      FS_WAIT_ROW,
      FS_WAIT_OFF,
      FS_WAIT_COL,
      FS_PUSH
   } front_state_type;

endpackage
`default_nettype wire

[rtl/rsrr_divu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsrr_divu: shared iterative divider
// Unsigned restoring division, one quotient bit per cycle. Used for both
// modulo reductions and for the rounded offset division.
// ----------------------------------------------------------------------------
module rsrr_divu (
   input  logic                   clock,
   input  logic                   reset,
   input  rsrr_pkg::div_req_type  div_req,
   output rsrr_pkg::div_status_type div_sts
);
   import rsrr_pkg::*;

   logic [DIV_NUM_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_SHIFT_BITS-1:0] den_ff, den_in;
   logic [DIV_QUO_BITS-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      fits;

   assign fits = rem_ff >= DIV_NUM_BITS'(den_ff);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         den_in  = {div_req.divisor, {(DIV_QUO_BITS-1){1'b0}}};
         quo_in  = '0;
         cnt_in  = DIV_CNT_BITS'(DIV_QUO_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_ff - DIV_NUM_BITS'(den_ff) : rem_ff;
         den_in  = den_ff >> 1;
         quo_in  = {quo_ff[DIV_QUO_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.quo  = quo_ff;
   assign div_sts.rem  = rem_ff;

endmodule
`default_nettype wire

[rtl/rsrr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsrr_front: request intake and address generation
// Writes are queued at once. Reads run a short sequencer that wraps the
// source row, forms the rounded shear/bend offset and wraps the column.
// ----------------------------------------------------------------------------
module rsrr_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512,
   parameter int ADDR_BITS  = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsrr_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,
   input  logic [rsrr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                q_full,
   output logic                                q_push,
   output rsrr_pkg::cmd_type                   q_cmd,
   output logic [ADDR_BITS-1:0]                q_addr,
   output rsrr_pkg::div_req_type               div_req,
   input  rsrr_pkg::div_status_type            div_sts
);
   import rsrr_pkg::*;

   front_state_type state_ff, state_in;

   logic [8:0]  req_col, req_row;
   pixel_type   req_pix;
   logic        accept, wr_in_store;

   logic [8:0]  x_ff, y_ff;
   logic [17:0] fh2_ff, fh2_in, d2_ff, d2_in;
   logic [8:0]  d_c;
   logic signed [20:0] sxy_ff, sxy_in;
   logic        bend_ff, bend_in;
   logic signed [39:0] p1_ff, p1_in;
   logic [32:0] p2_ff, p2_in;
   logic signed [40:0] num_c;
   logic [40:0] abs_c;
   logic [25:0] den_ff, den_in;
   logic [37:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [9:0]  sy_ff, sy_in;
   logic        bar_ff, bar_in;
   logic signed [13:0] off_c, v_c;
   logic [13:0] vabs_c;
   logic        vneg_ff, vneg_in;
   logic [9:0]  sx_ff, sx_in, rem10;

   logic [9:0]  w_sat, h_sat;
   logic [6:0]  h_div8, bar_rows, h_div24;
   logic [17:0] h_prod;

   assign req_col = req_tdata[8:0];
   assign req_row = req_tdata[17:9];
   assign req_pix = pixel_type'(req_tdata[49:18]);
   assign accept  = req_tvalid && req_tready;
   assign wr_in_store = (32'(req_col) < 32'(MAX_WIDTH)) && (32'(req_row) < 32'(MAX_HEIGHT));

   // Active frame size, held to 1..store size.
   always_comb begin
      if (cfg.frame_width == 10'd0) begin
         w_sat = 10'd1;
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w_sat = 10'(MAX_WIDTH);
      end else begin
         w_sat = cfg.frame_width;
      end
      if (cfg.frame_height == 10'd0) begin
         h_sat = 10'd1;
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         h_sat = 10'(MAX_HEIGHT);
      end else begin
         h_sat = cfg.frame_height;
      end
   end

   // Bar height is max(2, h/24); h/24 is (h/8)/3 by a reciprocal multiply.
   assign h_div8   = h_sat[9:3];
   assign h_prod   = 18'(h_div8) * 18'd683;
   assign h_div24  = h_prod[17:11];
   assign bar_rows = (h_div24 < 7'd2) ? 7'd2 : h_div24;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept && req_tuser) begin
               state_in = FS_MUL1;
            end
         end
         FS_MUL1: state_in = FS_MUL2;
         FS_MUL2: state_in = FS_SUM;
         FS_SUM:  state_in = FS_WAIT_ROW;
         FS_WAIT_ROW: begin
            if (!div_sts.busy) begin
               state_in = FS_WAIT_OFF;
            end
         end
         FS_WAIT_OFF: begin
            if (!div_sts.busy) begin
               state_in = FS_WAIT_COL;
            end
         end
         FS_WAIT_COL: begin
            if (!div_sts.busy) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!q_full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   // Offset and column arithmetic seen while the divider results land.
   always_comb begin
      off_c  = neg_ff ? -$signed({2'b00, div_sts.quo}) : $signed({2'b00, div_sts.quo});
      v_c    = $signed({5'd0, x_ff}) - off_c;
      vabs_c = v_c[13] ? 14'(-v_c) : 14'(v_c);
      rem10  = div_sts.rem[9:0];
   end

   // Outputs.
   always_comb begin
      req_tready       = 1'b0;
      q_push           = 1'b0;
      q_cmd            = '0;
      q_addr           = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         FS_IDLE: begin
            req_tready   = !q_full;
            q_push       = accept && !req_tuser && wr_in_store;
            q_cmd.is_read = 1'b0;
            q_cmd.pix    = req_pix;
            q_addr       = ADDR_BITS'(req_row) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(req_col);
         end
         FS_MUL1: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NUM_BITS'(y_ff) + DIV_NUM_BITS'(cfg.roll_offset);
            div_req.divisor  = DIV_DEN_BITS'(h_sat);
         end
         FS_WAIT_ROW: begin
            div_req.start    = !div_sts.busy;
            div_req.dividend = mag_ff;
            div_req.divisor  = den_ff;
         end
         FS_WAIT_OFF: begin
            div_req.start    = !div_sts.busy;
            div_req.dividend = DIV_NUM_BITS'(vabs_c);
            div_req.divisor  = DIV_DEN_BITS'(w_sat);
         end
         FS_PUSH: begin
            q_push         = !q_full;
            q_cmd.is_read  = 1'b1;
            q_cmd.in_blank = bar_ff;
            q_addr         = ADDR_BITS'(sy_ff) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(sx_ff);
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      d_c     = cfg.flag_height - y_ff;
      bend_in = (cfg.flag_height != 9'd0) && (y_ff < cfg.flag_height);
      fh2_in  = 18'(cfg.flag_height) * 18'(cfg.flag_height);
      d2_in   = 18'(d_c) * 18'(d_c);
      sxy_in  = cfg.shear_q8 * $signed({1'b0, y_ff});

      p1_in = sxy_ff * $signed({1'b0, fh2_ff});
      p2_in = 33'(cfg.flag_amplitude_q8) * 33'(d2_ff);

      if (bend_ff) begin
         num_c  = p1_ff + $signed({8'd0, p2_ff});
         den_in = {fh2_ff, 8'd0};
      end else begin
         num_c  = sxy_ff;
         den_in = 26'd256;
      end
      abs_c  = num_c[40] ? 41'(-num_c) : 41'(num_c);
      neg_in = num_c[40];
      mag_in = abs_c[37:0] + {12'd0, den_in >> 1};

      sy_in  = rem10;
      bar_in = (cfg.roll_offset != 10'd0) &&
               ((11'(rem10) + 11'(bar_rows)) >= 11'(h_sat));
      vneg_in = v_c[13];
      sx_in  = (vneg_ff && rem10 != 10'd0) ? w_sat - rem10 : rem10;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == FS_IDLE && accept) begin
         x_ff <= req_col;
         y_ff <= req_row;
      end
      if (state_ff == FS_MUL1) begin
         fh2_ff  <= fh2_in;
         d2_ff   <= d2_in;
         sxy_ff  <= sxy_in;
         bend_ff <= bend_in;
      end
      if (state_ff == FS_MUL2) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (state_ff == FS_SUM) begin
         den_ff <= den_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (state_ff == FS_WAIT_ROW && !div_sts.busy) begin
         sy_ff  <= sy_in;
         bar_ff <= bar_in;
      end
      if (state_ff == FS_WAIT_OFF && !div_sts.busy) begin
         vneg_ff <= vneg_in;
      end
      if (state_ff == FS_WAIT_COL && !div_sts.busy) begin
         sx_ff <= sx_in;
      end
   end

endmodule
`default_nettype wire

[rtl/rsrr_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsrr_queue: command queue between front and back end
// A small first-in first-out buffer; push and pop may happen together.
// ----------------------------------------------------------------------------
module rsrr_queue #(
   parameter int WIDTH = 52
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   import rsrr_pkg::*;

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

[rtl/rsrr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsrr_back: frame store and response stage
// Executes queued commands against the frame store memory and presents
// read results, dimmed inside the blanking bar, in an output register.
// ----------------------------------------------------------------------------
module rsrr_back #(
   parameter int DEPTH        = 262144,
   parameter int ADDR_BITS    = 18,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  rsrr_pkg::cmd_type                  q_cmd,
   input  logic [ADDR_BITS-1:0]               q_addr,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rsrr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tuser
);
   import rsrr_pkg::*;

   logic [4*CHANNEL_BITS-1:0] store [DEPTH];
   logic [4*CHANNEL_BITS-1:0] rd_data_ff, wr_word;

   logic      rd_pend_ff, rd_pend_in;
   logic      bar_pend_ff;
   logic      out_valid_ff, out_valid_in;
   logic      out_bar_ff;
   pixel_type out_pix_ff, out_pix_in;
   pixel_type raw_pix;
   logic      issue_read;

   // A read is issued only when the output register is free by the time
   // the memory data arrives.
   assign issue_read = !q_empty && q_cmd.is_read && !rd_pend_ff &&
                       (!out_valid_ff || rsp_tready);
   assign q_pop = issue_read || (!q_empty && !q_cmd.is_read);

   assign wr_word = {CHANNEL_BITS'(q_cmd.pix.alpha), CHANNEL_BITS'(q_cmd.pix.blue),
                     CHANNEL_BITS'(q_cmd.pix.green), CHANNEL_BITS'(q_cmd.pix.red)};

   always_ff @(posedge clock) begin
      if (q_pop && !q_cmd.is_read) begin
         store[q_addr] <= wr_word;
      end
      if (issue_read) begin
         rd_data_ff  <= store[q_addr];
         bar_pend_ff <= q_cmd.in_blank;
      end
   end

   assign raw_pix.red   = rd_data_ff[0*CHANNEL_BITS +: 8];
   assign raw_pix.green = rd_data_ff[1*CHANNEL_BITS +: 8];
   assign raw_pix.blue  = rd_data_ff[2*CHANNEL_BITS +: 8];
   assign raw_pix.alpha = rd_data_ff[3*CHANNEL_BITS +: 8];

   // Divide by six as a multiply by 171/1024, exact for 8-bit values.
   function automatic logic [7:0] div6(input logic [7:0] v);
      logic [16:0] prod;
      prod = 17'(v) * 17'd171;
      return 8'(prod >> 10);
   endfunction

   always_comb begin
      rd_pend_in   = issue_read;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_pix_in   = raw_pix;
      if (bar_pend_ff) begin
         out_pix_in.red   = div6(raw_pix.red);
         out_pix_in.green = div6(raw_pix.green);
         out_pix_in.blue  = div6(raw_pix.blue);
      end
      if (rd_pend_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      if (rd_pend_ff) begin
         out_pix_ff <= out_pix_in;
         out_bar_ff <= bar_pend_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = out_bar_ff;

endmodule
`default_nettype wire

[rtl/raster_shear_roll_remap.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// raster_shear_roll_remap: frame store with sheared, bent and rolled readout
// Source pixels are written into a frame store and read back through a
// row roll, a per-row horizontal shear plus a top-of-frame bend, and a
// dimmed blanking bar at the bottom of the source frame.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ stream. req_tuser low is a pixel write, which
// produces no response; req_tuser high is a read of one output pixel, which
// produces exactly one response on the rsp_ stream, in request order.
// A write is pushed into the queue when it is accepted and reaches the store
// once the back end pops it, so writes can stream at one per clock while no
// read is being sequenced and the queue drains. A read holds the front end
// through three passes of the shared divider (row wrap, rounded offset,
// column wrap) plus the multiply, sum and push steps. After the read leaves
// the queue, the response passes memory read, dimming and output register.
// When the receiver holds rsp_tready low, the result stays in the output
// register; writes ahead of the next read keep draining, that read and all
// behind it wait in the queue, and req_tready drops once the queue is full.
// Reset clears the control state and loads the register defaults; the
// frame store itself is not cleared and holds garbage until written.
// The user must write configuration on the csr_ port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module raster_shear_roll_remap #(
   parameter int MAX_WIDTH    = 512,
   parameter int MAX_HEIGHT   = 512,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata: col[8:0], row[17:9], in_red[25:18], in_green[33:26],
   // in_blue[41:34], in_alpha[49:42], zero fill above.
   input  logic [rsrr_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // req_tuser: func (0 write, 1 read).
   input  logic                                 req_tuser,
   // Response stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24].
   output logic [rsrr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // rsp_tuser: in_blanking.
   output logic                                 rsp_tuser,
   // Configuration write port.
   input  logic                                 csr_wr_en,
   input  logic [rsrr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rsrr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rsrr_pkg::*;

   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int Q_WIDTH   = $bits(cmd_type) + ADDR_BITS;

   cfg_type cfg_ff, cfg_in;

   logic                 q_push, q_pop, q_full, q_empty;
   cmd_type              push_cmd, pop_cmd;
   logic [ADDR_BITS-1:0] push_addr, pop_addr;
   logic [Q_WIDTH-1:0]   pop_word;

   div_req_type    div_req;
   div_status_type div_sts;

   // Configuration registers. Writes to unused indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_FRAME_WIDTH:  cfg_in.frame_width       = csr_wdata[9:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height      = csr_wdata[9:0];
            REG_SHEAR_Q8:     cfg_in.shear_q8          = $signed(csr_wdata[10:0]);
            REG_FLAG_AMP_Q8:  cfg_in.flag_amplitude_q8 = csr_wdata[14:0];
            REG_FLAG_HEIGHT:  cfg_in.flag_height       = csr_wdata[8:0];
            REG_ROLL_OFFSET:  cfg_in.roll_offset       = csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width       <= RST_FRAME_WIDTH;
         cfg_ff.frame_height      <= RST_FRAME_HEIGHT;
         cfg_ff.shear_q8          <= $signed(RST_SHEAR_Q8);
         cfg_ff.flag_amplitude_q8 <= RST_FLAG_AMP_Q8;
         cfg_ff.flag_height       <= RST_FLAG_HEIGHT;
         cfg_ff.roll_offset       <= RST_ROLL_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies requests and computes store addresses.
   rsrr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .q_addr     (push_addr),
      .div_req    (div_req),
      .div_sts    (div_sts)
   );

   rsrr_divu u_divu (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // Queue decouples address generation from memory access.
   rsrr_queue #(
      .WIDTH (Q_WIDTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   ({push_cmd, push_addr}),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (pop_word),
      .empty (q_empty)
   );

   assign pop_cmd  = cmd_type'(pop_word[Q_WIDTH-1:ADDR_BITS]);
   assign pop_addr = pop_word[ADDR_BITS-1:0];

   // The back end owns the frame store and the response register.
   rsrr_back #(
      .DEPTH        (DEPTH),
      .ADDR_BITS    (ADDR_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (pop_cmd),
      .q_addr     (pop_addr),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

[tb/raster_shear_roll_remap_tb.sv]
// ----------------------------------------------------------------------------
// raster_shear_roll_remap_tb: self-checking bench for the shear/roll remapper
// Streams pixel writes and remapped reads into the block under random stalls
// on both sides, predicts every read from a private copy of the frame store
// and the registers, and compares each response field by field.
// ----------------------------------------------------------------------------
module raster_shear_roll_remap_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rsrr_pkg::*;

   localparam int MAX_COLS    = 512;
   localparam int MAX_ROWS    = 512;
   localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

   // Request kinds carried on req_tuser.
   localparam bit FUNC_WRITE = 1'b0;
   localparam bit FUNC_READ  = 1'b1;

   localparam int ITEM_TARGET  = 1250;
   localparam int PHASE_ITEMS  = 90;
   // This covers any write or read that may still be inside the block.
   localparam int TAIL_CYCLES  = 64;
   // Cycles without any handshake before the run is declared hung.
   localparam int HANG_LIMIT   = 4000;

   typedef struct {
      pixel_type pix;
      logic      blank;
   } read_result_t;

   // Holds the predicted register state and frame store, turns accepted
   // requests into expected read results and compares the responses.
   class remap_scoreboard;
      logic [9:0]         frame_w;
      logic [9:0]         frame_h;
      logic signed [10:0] shear;
      logic [14:0]        bend_amp;
      logic [8:0]         bend_rows;
      logic [9:0]         roll;
      pixel_type          store [STORE_DEPTH];
      bit                 written [STORE_DEPTH];
      read_result_t       due [$];
      int                 errors;
      int                 writes;
      int                 reads;
      int                 dimmed;

      function new();
         frame_w   = RST_FRAME_WIDTH;
         frame_h   = RST_FRAME_HEIGHT;
         shear     = RST_SHEAR_Q8;
         bend_amp  = RST_FLAG_AMP_Q8;
         bend_rows = RST_FLAG_HEIGHT;
         roll      = RST_ROLL_OFFSET;
         errors    = 0;
         writes    = 0;
         reads     = 0;
         dimmed    = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [14:0] value);
         case (idx)
            REG_FRAME_WIDTH:  frame_w   = value[9:0];
            REG_FRAME_HEIGHT: frame_h   = value[9:0];
            REG_SHEAR_Q8:     shear     = value[10:0];
            REG_FLAG_AMP_Q8:  bend_amp  = value[14:0];
            REG_FLAG_HEIGHT:  bend_rows = value[8:0];
            REG_ROLL_OFFSET:  roll      = value[9:0];
            default: ;
         endcase
      endfunction

      // Frame sizes are clamped into the store before use.
      function int active_cols();
         if (frame_w == 0) return 1;
         if (frame_w > MAX_COLS) return MAX_COLS;
         return frame_w;
      endfunction

      function int active_rows();
         if (frame_h == 0) return 1;
         if (frame_h > MAX_ROWS) return MAX_ROWS;
         return frame_h;
      endfunction

      function longint round_half_away(longint num, longint den);
         if (num >= 0) return (num + den / 2) / den;
         return -((-num + den / 2) / den);
      endfunction

      // Finds the store entry shown at an output pixel and whether that
      // source row falls in the dimmed bar.
      function void map_read(input logic [8:0] col, input logic [8:0] row,
                             output int unsigned addr, output bit blank);
         longint w, h, x, y, src_row, src_col, bar, sh, fh, d, num, den, off;
         w = active_cols();
         h = active_rows();
         x = col;
         y = row;
         src_row = (y + roll) % h;
         bar = h / 24;
         if (bar < 2) bar = 2;
         blank = (roll != 0) && (src_row >= h - bar);
         sh = shear;
         fh = bend_rows;
         // The bend only applies to the top rows; both terms share one
         // denominator so the offset is rounded exactly once.
         if (fh > 0 && y < fh) begin
            d   = fh - y;
            num = sh * y * fh * fh + longint'(bend_amp) * d * d;
            den = 256 * fh * fh;
         end else begin
            num = sh * y;
            den = 256;
         end
         off = round_half_away(num, den);
         src_col = (x - off) % w;
         if (src_col < 0) src_col += w;
         addr = int'(src_row * MAX_COLS + src_col);
      endfunction

      function void note_request(bit func, logic [8:0] col, logic [8:0] row,
                                 pixel_type pix);
         int unsigned  addr;
         bit           blank;
         read_result_t res;
         if (func == FUNC_WRITE) begin
            addr = {row, col};
            store[addr] = pix;
            written[addr] = 1'b1;
            writes++;
         end else begin
            map_read(col, row, addr, blank);
            res.pix = store[addr];
            res.blank = blank;
            if (blank) begin
               res.pix.red   = res.pix.red / 8'd6;
               res.pix.green = res.pix.green / 8'd6;
               res.pix.blue  = res.pix.blue / 8'd6;
               dimmed++;
            end
            due.push_back(res);
            reads++;
         end
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         if (errors <= 40)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
      endtask

      task check_response(logic [31:0] data, logic blank);
         read_result_t res;
         pixel_type    got;
         got = pixel_type'(data);
         if (due.size() == 0) begin
            report("response with no read pending", data, 0);
            return;
         end
         res = due.pop_front();
         if (got.red !== res.pix.red) report("red", got.red, res.pix.red);
         if (got.green !== res.pix.green) report("green", got.green, res.pix.green);
         if (got.blue !== res.pix.blue) report("blue", got.blue, res.pix.blue);
         if (got.alpha !== res.pix.alpha) report("alpha", got.alpha, res.pix.alpha);
         if (blank !== res.blank) report("blanking flag", blank, res.blank);
      endtask

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // req_tdata: col, row, in_red, in_green, in_blue, in_alpha, zero fill.
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   // req_tuser: func.
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // rsp_tdata: out_red, out_green, out_blue, out_alpha.
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   // rsp_tuser: in_blanking.
   logic                      rsp_tuser;
   logic                      csr_wr_en;
   csr_index_type             csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   remap_scoreboard sb;
   bit              steady;       // when set, neither side idles
   int              sent;         // requests accepted so far
   int              settings;     // register settings applied
   int              stall_left;
   int              quiet_cycles;

   raster_shear_roll_remap dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mostly no gap, sometimes a short gap, now and then a long pause.
   function automatic int pick_gap();
      int roll_dice;
      if (steady) return 0;
      roll_dice = $urandom_range(0, 99);
      if (roll_dice < 60) return 0;
      if (roll_dice < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // The receiver stalls at random, except during steady stretches.
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Every accepted response is checked against the oldest pending read.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   // The run is hung if no request and no response moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d reads still pending",
                     HANG_LIMIT, sb.pending());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Sends one request, idling first for a random gap. The valid stays up
   // between back-to-back requests.
   task send_request(bit func, logic [8:0] col, logic [8:0] row, pixel_type pix);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'd0, pix.alpha, pix.blue, pix.green, pix.red, row, col};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, col, row, pix);
      sent++;
   endtask

   // A read never touches a store entry that was never written, so the
   // source pixel is written first when it is still empty.
   task read_pixel(logic [8:0] col, logic [8:0] row);
      int unsigned addr;
      bit          blank;
      sb.map_read(col, row, addr, blank);
      if (!sb.written[addr])
         send_request(FUNC_WRITE, addr[8:0], addr[17:9], pixel_type'($urandom));
      send_request(FUNC_READ, col, row, pixel_type'($urandom));
   endtask

   // Stops sending until every pending read has answered, then lets the
   // given number of cycles pass for writes still in flight.
   task wait_idle(int tail);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task put_reg(csr_index_type idx, logic [14:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // Registers change only with the block drained and quiet.
   task write_regs(logic [9:0] w, logic [9:0] h, logic [10:0] shear_q8,
                   logic [14:0] amp_q8, logic [8:0] bend_rows, logic [9:0] roll_rows);
      wait_idle(TAIL_CYCLES);
      put_reg(REG_FRAME_WIDTH, 15'(w));
      put_reg(REG_FRAME_HEIGHT, 15'(h));
      put_reg(REG_SHEAR_Q8, 15'(shear_q8));
      put_reg(REG_FLAG_AMP_Q8, amp_q8);
      put_reg(REG_FLAG_HEIGHT, 15'(bend_rows));
      put_reg(REG_ROLL_OFFSET, 15'(roll_rows));
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   // Small frames dominate so that wrapping and the bar are hit often;
   // full-range values still show up to exercise clamping.
   function automatic logic [9:0] random_size();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return $urandom_range(1, 64);
      if (pick < 8) return $urandom_range(65, 512);
      return $urandom_range(0, 1023);
   endfunction

   task random_settings();
      logic [10:0] shear_q8;
      logic [8:0]  bend_rows;
      logic [9:0]  roll_rows;
      if ($urandom_range(0, 9) < 3) shear_q8 = 11'($signed($urandom_range(0, 128)) - 64);
      else shear_q8 = $urandom_range(0, 2047);
      case ($urandom_range(0, 4))
         0:       bend_rows = 9'd0;
         1:       bend_rows = $urandom_range(65, 511);
         default: bend_rows = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 3))
         0:       roll_rows = 10'd0;
         1:       roll_rows = $urandom_range(0, 1023);
         default: roll_rows = $urandom_range(1, 64);
      endcase
      write_regs(random_size(), random_size(), shear_q8, $urandom_range(0, 32767),
                 bend_rows, roll_rows);
   endtask

   // Reads mostly land inside the active frame; writes mostly fill it and
   // sometimes land elsewhere in the store, where they must be kept.
   task random_request();
      int          pick;
      int          w;
      int          h;
      logic [8:0]  col;
      logic [8:0]  row;
      w = sb.active_cols();
      h = sb.active_rows();
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
         col = $urandom_range(0, w - 1);
         row = $urandom_range(0, h - 1);
      end else begin
         col = $urandom_range(0, 511);
         row = $urandom_range(0, 511);
      end
      if (pick < 50) begin
         read_pixel(col, row);
      end else if (pick < 85) begin
         send_request(FUNC_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                      pixel_type'($urandom));
      end else begin
         send_request(FUNC_WRITE, col, row, pixel_type'($urandom));
      end
      if ($urandom_range(0, 99) == 0)
         wait_idle(0);
   endtask

   initial begin
      int phase_end;
      sb = new();
      sent = 0;
      settings = 0;
      steady = 1'b0;
      stall_left = 0;
      quiet_cycles = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_WRITE;
      rsp_tready <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= REG_FRAME_WIDTH;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Register defaults after reset: corners of the store and both sides
      // of the bend boundary.
      send_request(FUNC_WRITE, 9'd0, 9'd0, pixel_type'(32'h0000_0000));
      send_request(FUNC_WRITE, 9'd511, 9'd511, pixel_type'(32'hFFFF_FFFF));
      send_request(FUNC_WRITE, 9'd511, 9'd0, pixel_type'(32'hAAAA_AAAA));
      send_request(FUNC_WRITE, 9'd0, 9'd511, pixel_type'(32'h5555_5555));
      read_pixel(9'd0, 9'd0);
      read_pixel(9'd511, 9'd511);
      read_pixel(9'd0, 9'd47);
      read_pixel(9'd0, 9'd48);
      read_pixel(9'd511, 9'd0);

      // Half a pixel per row: odd rows sit exactly on a rounding tie, which
      // must round away from zero for both signs of the shear.
      write_regs(10'd512, 10'd512, 11'sd128, 15'd0, 9'd0, 10'd0);
      read_pixel(9'd0, 9'd1);
      read_pixel(9'd0, 9'd3);
      read_pixel(9'd511, 9'd2);
      write_regs(10'd512, 10'd512, -11'sd128, 15'd0, 9'd0, 10'd0);
      read_pixel(9'd0, 9'd1);
      read_pixel(9'd0, 9'd3);

      // Random phases. The first few pin the extremes: zero sizes that
      // clamp to one, oversize frames, a bar taller than the frame, zero
      // bend height and rolls past the frame.
      for (int phase = 0; sent < ITEM_TARGET; phase++) begin
         case (phase)
            0: write_regs(10'd0, 10'd0, -11'sd1024, 15'd32767, 9'd511, 10'd1023);
            1: write_regs(10'd1023, 10'd1023, 11'sd1023, 15'd0, 9'd1, 10'd0);
            2: write_regs(10'd16, 10'd2, -11'sd768, 15'd16384, 9'd256, 10'd1);
            3: write_regs(10'd37, 10'd48, 11'sd38, 15'd3072, 9'd48, 10'd5);
            4: write_regs(10'd64, 10'd100, -11'sd128, 15'd0, 9'd0, 10'd512);
            default: random_settings();
         endcase
         steady = (phase % 4 == 3);
         phase_end = sent + PHASE_ITEMS;
         while (sent < phase_end && sent < ITEM_TARGET)
            random_request();
      end
      steady = 1'b0;

      wait_idle(TAIL_CYCLES);
      $display("Covered %0d pixel writes and %0d remapped reads (%0d in the blanking bar)",
               sb.writes, sb.reads, sb.dimmed);
      $display("across %0d register settings, with %0d mismatches.", settings, sb.errors);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
